### rtl/rat_pkg.sv
// Package for the region address translator.
// Holds the field widths, the status and function codes and the region entry type.
// No dependencies.
package rat_pkg;

  localparam int unsigned AddrW          = 48;
  localparam int unsigned LenW           = 32;
  localparam int unsigned CopyW          = 32;
  localparam int unsigned StatusW        = 3;
  localparam int unsigned RegionSlotsDef = 512;

  localparam logic FuncRegister  = 1'b0;
  localparam logic FuncTranslate = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StatusOk        = 3'd0,
    StatusEmpty     = 3'd1,
    StatusDuplicate = 3'd2,
    StatusFull      = 3'd3,
    StatusNotFound  = 3'd4,
    StatusOverflow  = 3'd5
  } status_e;

  // One stored region as it sits in the region memory.
  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [LenW-1:0]  length;
    logic [CopyW-1:0] copy_base;
  } region_t;

endpackage

### rtl/rat_req_if.sv
// Request channel of the region address translator: valid, ready and the item fields.
// Depends on rat_pkg.
interface rat_req_if import rat_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [AddrW-1:0] address;
  logic [LenW-1:0]  length;
  logic [CopyW-1:0] copy_base;

  modport source (output valid, func, address, length, copy_base, input ready);
  modport sink   (input valid, func, address, length, copy_base, output ready);
endinterface

### rtl/rat_rsp_if.sv
// Response channel of the region address translator: valid, ready and the result fields.
// Depends on rat_pkg.
interface rat_rsp_if import rat_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CopyW-1:0]   translated;
  logic [StatusW-1:0] status;

  modport source (output valid, translated, status, input ready);
  modport sink   (input valid, translated, status, output ready);
endinterface

### rtl/rat_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module rat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/region_address_translator.sv
// Region address translator top level.
// Depends on rat_pkg, rat_req_if, rat_rsp_if and rat_ram.
//
// The block keeps a table of address regions (source base, length, copy base)
// in one synchronous memory and answers one request beat with one response beat.
// A request with func set to register adds a region unless it is empty, repeats
// a stored base and length, or the table is full. A request with func set to
// translate finds the first stored region, in insertion order, whose closed
// range [base, base + length] holds the address and returns copy base plus the
// offset, or flags a miss or a sum that does not fit in 32 bits.
// Both channels use a valid/ready handshake; a beat moves when both are high.
// An empty register request or a zero translate address is answered without a
// scan. Any other request scans the stored entries one per cycle through the
// memory read port. The scan stops at the first matching entry or after the
// last stored entry.
// One request is worked on at a time; ready is high while the block is idle.
// The finished response sits in an output register, so a new request is taken
// while the receiver stalls; a second result then waits until the first beat
// is taken. Reset clears the entry count and all handshake state; the region
// memory needs no clearing, since only entries below the count are ever read.
module region_address_translator import rat_pkg::*; #(
  parameter int unsigned REGION_SLOTS = RegionSlotsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rat_req_if.sink  req_i,
  rat_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(REGION_SLOTS + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StAdd  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic             pend_q, pend_d;

  // Latched request.
  logic             func_q;
  logic [AddrW-1:0] addr_q;
  logic [LenW-1:0]  len_q;
  logic [CopyW-1:0] copy_q;

  // Hit data carried into the add cycle.
  logic [CopyW-1:0] hcopy_q, hcopy_d;
  logic [LenW-1:0]  off_q, off_d;

  // Finished result waiting for the output register.
  status_e          res_status_q, res_status_d;
  logic [CopyW-1:0] res_trans_q, res_trans_d;

  logic               rsp_valid_q, rsp_valid_d;
  logic [StatusW-1:0] rsp_status_q;
  logic [CopyW-1:0]   rsp_trans_q;
  logic               rsp_load;

  logic      req_fire;
  logic      ram_we, ram_re;
  region_t   ram_wdata, ram_rdata;

  logic [AddrW:0]   diff;
  logic             hit, dup, match, at_end;
  logic [CopyW:0]   sum;

  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;

  // Entry compare on the word read last cycle. The subtraction gives both the
  // lower bound (no borrow) and the offset checked against the length.
  assign diff  = {1'b0, addr_q} - {1'b0, ram_rdata.base};
  assign hit   = !diff[AddrW] && (diff[AddrW-1:LenW] == '0) && (diff[LenW-1:0] <= ram_rdata.length);
  assign dup   = (ram_rdata.base == addr_q) && (ram_rdata.length == len_q);
  assign match = pend_q && ((func_q == FuncTranslate) ? hit : dup);
  // No read outstanding beyond the last stored entry.
  assign at_end = (idx_q == count_q);

  assign sum = {1'b0, hcopy_q} + {1'b0, off_q};

  assign ram_re    = (state_q == StScan) && (idx_q < count_q);
  assign ram_wdata = '{base: addr_q, length: len_q, copy_base: copy_q};

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    pend_d       = 1'b0;
    hcopy_d      = hcopy_q;
    off_d        = off_q;
    res_status_d = res_status_q;
    res_trans_d  = res_trans_q;
    ram_we       = 1'b0;
    rsp_load     = 1'b0;

    case (state_q)
      StIdle: begin
        if (req_fire) begin
          idx_d       = '0;
          res_trans_d = '0;
          if (req_i.func == FuncRegister &&
              (req_i.address == '0 || req_i.length == '0)) begin
            res_status_d = StatusEmpty;
            state_d      = StDone;
          end else if (req_i.func == FuncTranslate && req_i.address == '0) begin
            res_status_d = StatusOk;
            state_d      = StDone;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (ram_re) begin
          idx_d  = idx_q + CntW'(1);
          pend_d = 1'b1;
        end
        if (match) begin
          if (func_q == FuncTranslate) begin
            hcopy_d = ram_rdata.copy_base;
            off_d   = diff[LenW-1:0];
            state_d = StAdd;
          end else begin
            res_status_d = StatusDuplicate;
            state_d      = StDone;
          end
        end else if (at_end) begin
          state_d = StDone;
          if (func_q == FuncTranslate) begin
            res_status_d = StatusNotFound;
          end else if (count_q == CntW'(REGION_SLOTS)) begin
            res_status_d = StatusFull;
          end else begin
            // The write lands at the count, which no read of this scan touches.
            ram_we       = 1'b1;
            count_d      = count_q + CntW'(1);
            res_status_d = StatusOk;
          end
        end
      end
      StAdd: begin
        if (sum[CopyW]) begin
          res_status_d = StatusOverflow;
        end else begin
          res_status_d = StatusOk;
          res_trans_d  = sum[CopyW-1:0];
        end
        state_d = StDone;
      end
      StDone: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      func_q <= req_i.func;
      addr_q <= req_i.address;
      len_q  <= req_i.length;
      copy_q <= req_i.copy_base;
    end
    hcopy_q      <= hcopy_d;
    off_q        <= off_d;
    res_status_q <= res_status_d;
    res_trans_q  <= res_trans_d;
    if (rsp_load) begin
      rsp_status_q <= res_status_q;
      rsp_trans_q  <= res_trans_q;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.translated = rsp_trans_q;

  rat_ram #(
    .WIDTH ($bits(region_t)),
    .DEPTH (REGION_SLOTS)
  ) u_region_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

endmodule
